// File: hw/rtl/pfbp_pkg.sv
`timescale 1ns / 1ps

package pfbp_pkg;

    localparam int FRAME_COUNT_DEF = 16;
    localparam int PAGE_W          = 31;
    localparam int PINS_W          = 8;
    localparam int CMD_W           = 3;
    localparam int FRAME_OUT_W     = 4;

    localparam logic [PINS_W-1:0] PINS_MAX = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_FETCH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEW    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_PIN   = 3'd1,
        OP_LOAD  = 3'd2,
        OP_UNPIN = 3'd3,
        OP_FLUSH = 3'd4,
        OP_FREE  = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     load_dirty;
        logic     mark_dirty;
        logic     rm_en;
    } cell_ctl_t;

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic              evictable;
        logic [PINS_W-1:0] pins;
    } cell_stat_t;

endpackage

// File: hw/rtl/page_frame_buffer_pool_top.sv
`timescale 1ns / 1ps
// Sequence: after the input transfer the command passes the match, pick and
// update states; the result is registered when the update state completes.
// A new command is taken only in the idle state; in_stall stays high through
// match, pick and update, and the output stall can hold the update.
// Reset: asynchronous, active low; all frames free and invalid, free queue holds
// frames in ascending order, recency order empty, no result pending.

module page_frame_buffer_pool_top
    import pfbp_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_W-1:0]       command,
    input  logic [PAGE_W-1:0]      page_id,
    input  logic                   mark_dirty,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   ok,
    output logic [FRAME_OUT_W-1:0] frame,
    output logic                   read_from_disk,
    output logic                   write_back,
    output logic [PAGE_W-1:0]      write_back_page,
    output logic                   release_page
);

    localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_PICK   = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Captured command.
    logic [CMD_W-1:0]  cmd_reg;
    logic [PAGE_W-1:0] pid_reg;
    logic              md_reg;

    // Frame cell row.
    cell_ctl_t         ctl;
    logic [FRAME_COUNT-1:0] sel;
    logic [IDX_W-1:0]  rm_rank, add_rank;
    logic [FRAME_COUNT-1:0] hit;
    cell_stat_t        c_stat [FRAME_COUNT];
    logic [PAGE_W-1:0] c_page [FRAME_COUNT];
    logic [IDX_W-1:0]  c_rank [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] lru_head;

    // Free queue chain.
    logic [IDX_W-1:0]  fq_val [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] fq_load;
    logic              fq_pop, fq_push;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]  ecnt_reg, ecnt_next;

    // Match results.
    logic [FRAME_COUNT-1:0] hit_vec_reg;
    logic [FRAME_COUNT-1:0] head_vec_reg;
    logic [IDX_W-1:0]  f_idx_reg, v_idx_reg;
    logic              found_reg, vfound_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   ok_reg, ok_next;
    logic [FRAME_OUT_W-1:0] frame_reg, frame_next;
    logic                   rd_reg, rd_next;
    logic                   wb_reg, wb_next;
    logic [PAGE_W-1:0]      wbp_reg, wbp_next;
    logic                   rel_reg, rel_next;

    logic update_go;

    function automatic logic [IDX_W-1:0] first_set(input logic [FRAME_COUNT-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_COUNT; gi++)
        begin : g_cells
            pfbp_cell #(
                .RANK_W (IDX_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .sel      (sel[gi]),
                .pid      (pid_reg),
                .rm_rank  (rm_rank),
                .add_rank (add_rank),
                .hit      (hit[gi]),
                .stat     (c_stat[gi]),
                .page     (c_page[gi]),
                .rank     (c_rank[gi])
            );
            assign lru_head[gi] = c_stat[gi].evictable && (c_rank[gi] == '0);

            // A pop hands each entry one step toward the head.
            pfbp_fq_cell #(
                .IDX_W     (IDX_W),
                .RESET_VAL (gi)
            ) u_fq (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (fq_pop),
                .shift_in ((gi == FRAME_COUNT - 1) ? fq_val[gi] : fq_val[(gi + 1) % FRAME_COUNT]),
                .load     (fq_load[gi]),
                .load_val (f_idx_reg),
                .value    (fq_val[gi])
            );
            assign fq_load[gi] = fq_push && (fcnt_reg == CNT_W'(gi));
        end
    endgenerate

    assign in_stall  = (state_reg != S_IDLE);
    assign update_go = (state_reg == S_UPDATE) && !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_MATCH;
            S_MATCH:  state_next = S_PICK;
            S_PICK:   state_next = S_UPDATE;
            S_UPDATE: if (update_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Decide the command's effect on the cells and the result.
    always_comb
    begin
        logic             claim_ok;
        logic             from_free;
        logic [IDX_W-1:0] claim_idx;
        cell_stat_t       fs;
        cell_stat_t       vs;

        from_free = (fcnt_reg != '0);
        claim_ok  = from_free || vfound_reg;
        claim_idx = from_free ? fq_val[0] : v_idx_reg;
        fs        = c_stat[f_idx_reg];
        vs        = c_stat[v_idx_reg];

        ctl        = '{op: OP_NONE, load_dirty: 1'b0, mark_dirty: md_reg, rm_en: 1'b0};
        sel        = '0;
        rm_rank    = c_rank[f_idx_reg];
        add_rank   = IDX_W'(ecnt_reg);
        fq_pop     = 1'b0;
        fq_push    = 1'b0;
        fcnt_next  = fcnt_reg;
        ecnt_next  = ecnt_reg;
        ok_next    = 1'b0;
        frame_next = '0;
        rd_next    = 1'b0;
        wb_next    = 1'b0;
        wbp_next   = '0;
        rel_next   = 1'b0;

        case (cmd_reg)
            CMD_FETCH, CMD_NEW:
            begin
                if (found_reg && (cmd_reg == CMD_FETCH))
                begin
                    if (fs.pins != PINS_MAX)
                    begin
                        ctl.op         = OP_PIN;
                        sel[f_idx_reg] = 1'b1;
                        ctl.rm_en      = fs.evictable;
                        if (fs.evictable)
                        begin
                            ecnt_next = ecnt_reg - 1'b1;
                        end
                        ok_next    = 1'b1;
                        frame_next = FRAME_OUT_W'(f_idx_reg);
                    end
                end
                else if (!found_reg && claim_ok)
                begin
                    ctl.op         = OP_LOAD;
                    ctl.load_dirty = (cmd_reg == CMD_NEW);
                    sel[claim_idx] = 1'b1;
                    ok_next        = 1'b1;
                    frame_next     = FRAME_OUT_W'(claim_idx);
                    rd_next        = (cmd_reg == CMD_FETCH);
                    if (from_free)
                    begin
                        fq_pop    = 1'b1;
                        fcnt_next = fcnt_reg - 1'b1;
                    end
                    else
                    begin
                        // evict the least recently unpinned frame
                        ctl.rm_en = 1'b1;
                        rm_rank   = c_rank[v_idx_reg];
                        ecnt_next = ecnt_reg - 1'b1;
                        if (vs.valid && vs.dirty)
                        begin
                            wb_next  = 1'b1;
                            wbp_next = c_page[v_idx_reg];
                        end
                    end
                end
            end
            CMD_UNPIN:
            begin
                if (found_reg && (fs.pins != '0))
                begin
                    ctl.op         = OP_UNPIN;
                    sel[f_idx_reg] = 1'b1;
                    if ((fs.pins == PINS_W'(1)) && !fs.evictable)
                    begin
                        ecnt_next = ecnt_reg + 1'b1;
                    end
                    ok_next    = 1'b1;
                    frame_next = FRAME_OUT_W'(f_idx_reg);
                end
            end
            CMD_FLUSH:
            begin
                if (found_reg)
                begin
                    ctl.op         = OP_FLUSH;
                    sel[f_idx_reg] = 1'b1;
                    wb_next        = 1'b1;
                    wbp_next       = pid_reg;
                    ok_next        = 1'b1;
                    frame_next     = FRAME_OUT_W'(f_idx_reg);
                end
            end
            CMD_DELETE:
            begin
                if (!found_reg)
                begin
                    ok_next  = 1'b1;
                    rel_next = 1'b1;
                end
                else if (fs.pins == '0)
                begin
                    ctl.op         = OP_FREE;
                    sel[f_idx_reg] = 1'b1;
                    ctl.rm_en      = fs.evictable;
                    if (fs.evictable)
                    begin
                        ecnt_next = ecnt_reg - 1'b1;
                    end
                    if (fcnt_reg < CNT_W'(FRAME_COUNT))
                    begin
                        fq_push   = 1'b1;
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    ok_next    = 1'b1;
                    rel_next   = 1'b1;
                    frame_next = FRAME_OUT_W'(f_idx_reg);
                end
            end
            default:
            begin
            end
        endcase

        // hold every side effect until the result can be written
        if (!update_go)
        begin
            ctl.op    = OP_NONE;
            ctl.rm_en = 1'b0;
            sel       = '0;
            fq_pop    = 1'b0;
            fq_push   = 1'b0;
            fcnt_next = fcnt_reg;
            ecnt_next = ecnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcnt_reg      <= CNT_W'(FRAME_COUNT);
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            ecnt_reg  <= ecnt_next;
            if (update_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            cmd_reg <= command;
            pid_reg <= page_id;
            md_reg  <= mark_dirty;
        end
        if (state_reg == S_MATCH)
        begin
            hit_vec_reg  <= hit;
            head_vec_reg <= lru_head;
        end
        if (state_reg == S_PICK)
        begin
            f_idx_reg  <= first_set(hit_vec_reg);
            found_reg  <= |hit_vec_reg;
            v_idx_reg  <= first_set(head_vec_reg);
            vfound_reg <= |head_vec_reg;
        end
        if (update_go)
        begin
            ok_reg    <= ok_next;
            frame_reg <= frame_next;
            rd_reg    <= rd_next;
            wb_reg    <= wb_next;
            wbp_reg   <= wbp_next;
            rel_reg   <= rel_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign frame           = frame_reg;
    assign read_from_disk  = rd_reg;
    assign write_back      = wb_reg;
    assign write_back_page = wbp_reg;
    assign release_page    = rel_reg;

endmodule

// File: hw/rtl/pfbp_cell.sv
`timescale 1ns / 1ps

module pfbp_cell
    import pfbp_pkg::*;
#(
    parameter int RANK_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic              sel,
    input  logic [PAGE_W-1:0] pid,
    input  logic [RANK_W-1:0] rm_rank,
    input  logic [RANK_W-1:0] add_rank,
    output logic              hit,
    output cell_stat_t        stat,
    output logic [PAGE_W-1:0] page,
    output logic [RANK_W-1:0] rank
);

    logic              valid_reg, valid_next;
    logic              dirty_reg, dirty_next;
    logic              ev_reg, ev_next;
    logic [PINS_W-1:0] pins_reg, pins_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [PAGE_W-1:0] page_reg, page_next;

    assign hit  = valid_reg && (page_reg == pid);
    assign stat = '{valid: valid_reg, dirty: dirty_reg, evictable: ev_reg, pins: pins_reg};
    assign page = page_reg;
    assign rank = rank_reg;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        ev_next    = ev_reg;
        pins_next  = pins_reg;
        rank_next  = rank_reg;
        page_next  = page_reg;
        // close the gap left by a frame that leaves the recency order
        if (ctl.rm_en && ev_reg && (rank_reg > rm_rank))
        begin
            rank_next = rank_reg - 1'b1;
        end
        if (sel)
        begin
            case (ctl.op)
                OP_PIN:
                begin
                    pins_next = pins_reg + 1'b1;
                    ev_next   = 1'b0;
                    rank_next = '0;
                end
                OP_LOAD:
                begin
                    valid_next = 1'b1;
                    page_next  = pid;
                    pins_next  = {{(PINS_W-1){1'b0}}, 1'b1};
                    dirty_next = ctl.load_dirty;
                    ev_next    = 1'b0;
                    rank_next  = '0;
                end
                OP_UNPIN:
                begin
                    dirty_next = dirty_reg | ctl.mark_dirty;
                    pins_next  = pins_reg - 1'b1;
                    if ((pins_reg == {{(PINS_W-1){1'b0}}, 1'b1}) && !ev_reg)
                    begin
                        ev_next   = 1'b1;
                        rank_next = add_rank;
                    end
                end
                OP_FLUSH:
                begin
                    dirty_next = 1'b0;
                end
                OP_FREE:
                begin
                    valid_next = 1'b0;
                    dirty_next = 1'b0;
                    ev_next    = 1'b0;
                    rank_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            ev_reg    <= 1'b0;
            pins_reg  <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            ev_reg    <= ev_next;
            pins_reg  <= pins_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

// File: hw/rtl/pfbp_fq_cell.sv
`timescale 1ns / 1ps

module pfbp_fq_cell
    import pfbp_pkg::*;
#(
    parameter int IDX_W     = 4,
    parameter int RESET_VAL = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [IDX_W-1:0] shift_in,
    input  logic             load,
    input  logic [IDX_W-1:0] load_val,
    output logic [IDX_W-1:0] value
);

    logic [IDX_W-1:0] val_reg, val_next;

    assign value = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (shift)
        begin
            val_next = shift_in;
        end
        else if (load)
        begin
            val_next = load_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= IDX_W'(RESET_VAL);
        end
        else
        begin
            val_reg <= val_next;
        end
    end

endmodule

// File: hw/rtl/pfbp_checker.sv
`timescale 1ns / 1ps

module pfbp_checker
    import pfbp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   ok,
    input logic [FRAME_OUT_W-1:0] frame,
    input logic                   read_from_disk,
    input logic                   write_back,
    input logic [PAGE_W-1:0]      write_back_page,
    input logic                   release_page
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame) && $stable(write_back_page))
        else $error("stalled result changed");

    a_fail_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> frame == '0 && !read_from_disk && !release_page)
        else $error("failed command reports a frame or an action");

    a_wb_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_back |-> write_back_page == '0)
        else $error("write-back page without write-back");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(read_from_disk && release_page))
        else $error("read and release in one result");

endmodule

bind page_frame_buffer_pool_top pfbp_checker u_pfbp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ok              (ok),
    .frame           (frame),
    .read_from_disk  (read_from_disk),
    .write_back      (write_back),
    .write_back_page (write_back_page),
    .release_page    (release_page)
);
